[rtl/core/matrix_transform_unit_defines.svh]
// ---------------------------------------------------------------------------
// Matrix transform unit assertion macros
// Concurrent checks clocked on clk_i and held off while rst_ni is low.
// ---------------------------------------------------------------------------
`ifndef MATRIX_TRANSFORM_UNIT_DEFINES_SVH
`define MATRIX_TRANSFORM_UNIT_DEFINES_SVH

`ifndef NO_ASSERTIONS
// Same-cycle implication.
`define MTU_ASSERT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);
// Next-cycle implication.
`define MTU_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);
`else
`define MTU_ASSERT(label, ante, cons, msg)
`define MTU_ASSERT_NEXT(label, ante, cons, msg)
`endif

`endif

[rtl/core/mtu_pkg.sv]
// ---------------------------------------------------------------------------
// Matrix transform unit package
// Widths, fixed-point format, command codes and shared types.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package mtu_pkg;

  localparam int unsigned DataW    = 32;
  localparam int unsigned FracBits = 16;
  // Width of a full product after the fraction shift.
  localparam int unsigned ProdW    = 2 * DataW - FracBits;
  // Four products summed without loss.
  localparam int unsigned SumW     = ProdW + 2;
  localparam int unsigned NumDim   = 4;
  localparam int unsigned NumElem  = NumDim * NumDim;
  localparam int unsigned IdxW     = $clog2(NumElem);

  typedef logic signed [DataW-1:0] data_t;

  // 1.0 in the fixed-point format
  localparam data_t FixOne = data_t'(1) <<< FracBits;

  typedef enum logic [2:0] {
    CMD_IDENTITY  = 3'd0,
    CMD_LOAD      = 3'd1,
    CMD_READ      = 3'd2,
    CMD_TRANSLATE = 3'd3,
    CMD_SCALE     = 3'd4,
    CMD_TRANSFORM = 3'd5
  } cmd_e;

endpackage

`default_nettype wire

[rtl/core/mtu_lane.sv]
// ---------------------------------------------------------------------------
// Matrix transform unit row lane
// Four fixed-point products of one matrix row, their saturated sum and the
// individually saturated products of the first three columns.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module mtu_lane (
  input  mtu_pkg::data_t m_i    [mtu_pkg::NumDim],
  input  mtu_pkg::data_t v_i    [mtu_pkg::NumDim],
  output mtu_pkg::data_t sum_o,
  output logic           sum_sat_o,
  output mtu_pkg::data_t prod_o [mtu_pkg::NumDim-1]
);

  logic signed [2*mtu_pkg::DataW-1:0] full [mtu_pkg::NumDim];
  logic signed [mtu_pkg::ProdW-1:0]   prod [mtu_pkg::NumDim];
  logic signed [mtu_pkg::SumW-1:0]    sum;

  // Floor by arithmetic shift of the exact product.
  always_comb begin
    for (int c = 0; c < mtu_pkg::NumDim; c++) begin
      full[c] = (2*mtu_pkg::DataW)'(m_i[c]) * (2*mtu_pkg::DataW)'(v_i[c]);
      prod[c] = mtu_pkg::ProdW'(full[c] >>> mtu_pkg::FracBits);
    end
  end

  always_comb begin
    sum = mtu_pkg::SumW'(prod[0]) + mtu_pkg::SumW'(prod[1])
        + mtu_pkg::SumW'(prod[2]) + mtu_pkg::SumW'(prod[3]);
  end

  // In range when the result sign and all bits above it agree.
  always_comb begin
    logic [mtu_pkg::SumW-mtu_pkg::DataW:0] hi;
    hi = sum[mtu_pkg::SumW-1:mtu_pkg::DataW-1];
    if ((&hi) || !(|hi)) begin
      sum_o     = sum[mtu_pkg::DataW-1:0];
      sum_sat_o = 1'b0;
    end else begin
      sum_o     = sum[mtu_pkg::SumW-1] ? {1'b1, {(mtu_pkg::DataW-1){1'b0}}}
                                       : {1'b0, {(mtu_pkg::DataW-1){1'b1}}};
      sum_sat_o = 1'b1;
    end
  end

  always_comb begin
    logic [mtu_pkg::ProdW-mtu_pkg::DataW:0] phi;
    for (int c = 0; c < mtu_pkg::NumDim - 1; c++) begin
      phi = prod[c][mtu_pkg::ProdW-1:mtu_pkg::DataW-1];
      if ((&phi) || !(|phi)) begin
        prod_o[c] = prod[c][mtu_pkg::DataW-1:0];
      end else begin
        prod_o[c] = prod[c][mtu_pkg::ProdW-1] ? {1'b1, {(mtu_pkg::DataW-1){1'b0}}}
                                              : {1'b0, {(mtu_pkg::DataW-1){1'b1}}};
      end
    end
  end

endmodule

`default_nettype wire

[rtl/core/matrix_transform_unit.sv]
// ---------------------------------------------------------------------------
// Matrix transform unit
// Holds one column-major 4x4 Q16.16 matrix and runs one command per request:
// identity, load, read, translate, scale or vector transform.
// ---------------------------------------------------------------------------
// The block takes one request per clock cycle unless stalled and, for read
// and transform, presents the result from a result register: the accepting
// edge captures the request, the edge on which it advances updates the matrix
// and the result register together, so a following request always sees the
// matrix left by the one before it. Identity, load, translate and scale
// return nothing; command codes 6 and 7 are dropped. Sixteen 32x32
// multipliers, one per matrix element, feed four row lanes; that multiply,
// shift, add and saturate path sets the clock. Products round toward minus
// infinity; each row sum saturates once to 32 bits and the saturated flag
// reports it for transform. Translate and scale clamp silently. The matrix
// comes out of reset as identity. Backpressure on the result side stalls a
// request that would produce a result while the result register is still
// full, and the request input with it until that result is taken.
`timescale 1ns / 1ps
`default_nettype none

`include "matrix_transform_unit_defines.svh"

module matrix_transform_unit (
  input  logic         clk_i,
  input  logic         rst_ni,
  // Request channel
  input  logic         s_axis_tvalid_i,
  output logic         s_axis_tready_o,
  // element_index [3:0], element_value [35:4], vec_x [67:36], vec_y [99:68],
  // vec_z [131:100], vec_w [163:132], zero fill [167:164]
  input  logic [167:0] s_axis_tdata_i,
  // command [2:0]
  input  logic [2:0]   s_axis_tuser_i,
  // Result channel
  output logic         m_axis_tvalid_o,
  input  logic         m_axis_tready_i,
  // out_x [31:0], out_y [63:32], out_z [95:64], out_w [127:96]
  output logic [127:0] m_axis_tdata_o,
  // saturated [0]
  output logic [0:0]   m_axis_tuser_o
);

  localparam int unsigned ND = mtu_pkg::NumDim;

  // Request register
  logic                     req_valid_q, req_valid_d;
  logic [2:0]               req_cmd_q;
  logic [mtu_pkg::IdxW-1:0] req_idx_q;
  mtu_pkg::data_t           req_value_q;
  mtu_pkg::data_t           req_vec_q [ND];

  // Matrix state
  mtu_pkg::data_t matrix_q [mtu_pkg::NumElem];
  mtu_pkg::data_t matrix_d [mtu_pkg::NumElem];

  // Result register
  logic           out_valid_q, out_valid_d;
  mtu_pkg::data_t out_q [ND];
  mtu_pkg::data_t out_d [ND];
  logic           out_sat_q, out_sat_d;

  logic emits;
  logic advance;
  logic s_accept;

  // Lane wiring
  mtu_pkg::data_t lane_m    [ND][ND];
  mtu_pkg::data_t lane_v    [ND];
  mtu_pkg::data_t lane_sum  [ND];
  logic           lane_sat  [ND];
  mtu_pkg::data_t lane_prod [ND][ND-1];

  // -------------------------------------------------------------------------
  // Handshake
  // -------------------------------------------------------------------------
  always_comb begin
    emits = (req_cmd_q == mtu_pkg::CMD_READ) || (req_cmd_q == mtu_pkg::CMD_TRANSFORM);
  end

  // Request leaves its register unless it needs a result slot that is held.
  assign advance         = req_valid_q && (!emits || !out_valid_q || m_axis_tready_i);
  assign s_axis_tready_o = !req_valid_q || advance;
  assign s_accept        = s_axis_tvalid_i && s_axis_tready_o;

  always_comb begin
    req_valid_d = s_accept || (req_valid_q && !advance);
    out_valid_d = (out_valid_q && !m_axis_tready_i) || (advance && emits);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      req_valid_q <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      req_valid_q <= req_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_accept) begin
      req_cmd_q    <= s_axis_tuser_i;
      req_idx_q    <= s_axis_tdata_i[3:0];
      req_value_q  <= s_axis_tdata_i[35:4];
      req_vec_q[0] <= s_axis_tdata_i[67:36];
      req_vec_q[1] <= s_axis_tdata_i[99:68];
      req_vec_q[2] <= s_axis_tdata_i[131:100];
      req_vec_q[3] <= s_axis_tdata_i[163:132];
    end
  end

  // -------------------------------------------------------------------------
  // Row lanes: lane r sees matrix row r, element c at column-major c*4+r
  // -------------------------------------------------------------------------
  always_comb begin
    lane_v[0] = req_vec_q[0];
    lane_v[1] = req_vec_q[1];
    lane_v[2] = req_vec_q[2];
    // translate adds the last column as-is: times 1.0 is exact
    lane_v[3] = (req_cmd_q == mtu_pkg::CMD_TRANSLATE) ? mtu_pkg::FixOne : req_vec_q[3];
  end

  for (genvar r = 0; r < ND; r++) begin : g_lane
    for (genvar c = 0; c < ND; c++) begin : g_col
      assign lane_m[r][c] = matrix_q[c*ND + r];
    end

    mtu_lane u_lane (
      .m_i       (lane_m[r]),
      .v_i       (lane_v),
      .sum_o     (lane_sum[r]),
      .sum_sat_o (lane_sat[r]),
      .prod_o    (lane_prod[r])
    );
  end

  // -------------------------------------------------------------------------
  // Matrix update
  // -------------------------------------------------------------------------
  always_comb begin
    matrix_d = matrix_q;
    if (advance) begin
      case (mtu_pkg::cmd_e'(req_cmd_q))
        mtu_pkg::CMD_IDENTITY: begin
          for (int i = 0; i < mtu_pkg::NumElem; i++) begin
            matrix_d[i] = ((i % (ND + 1)) == 0) ? mtu_pkg::FixOne : '0;
          end
        end
        mtu_pkg::CMD_LOAD: begin
          matrix_d[req_idx_q] = req_value_q;
        end
        mtu_pkg::CMD_TRANSLATE: begin
          for (int r = 0; r < ND; r++) begin
            matrix_d[(ND-1)*ND + r] = lane_sum[r];
          end
        end
        mtu_pkg::CMD_SCALE: begin
          for (int c = 0; c < ND - 1; c++) begin
            for (int r = 0; r < ND; r++) begin
              matrix_d[c*ND + r] = lane_prod[r][c];
            end
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < mtu_pkg::NumElem; i++) begin
        matrix_q[i] <= ((i % (ND + 1)) == 0) ? mtu_pkg::FixOne : '0;
      end
    end else begin
      matrix_q <= matrix_d;
    end
  end

  // -------------------------------------------------------------------------
  // Result register
  // -------------------------------------------------------------------------
  always_comb begin
    if (req_cmd_q == mtu_pkg::CMD_READ) begin
      out_d[0]  = matrix_q[req_idx_q];
      out_d[1]  = '0;
      out_d[2]  = '0;
      out_d[3]  = '0;
      out_sat_d = 1'b0;
    end else begin
      out_d     = lane_sum;
      out_sat_d = lane_sat[0] | lane_sat[1] | lane_sat[2] | lane_sat[3];
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance && emits) begin
      out_q     <= out_d;
      out_sat_q <= out_sat_d;
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = {out_q[3], out_q[2], out_q[1], out_q[0]};
  assign m_axis_tuser_o  = out_sat_q;

  // -------------------------------------------------------------------------
  // Checks
  // -------------------------------------------------------------------------
  `MTU_ASSERT(a_no_overwrite, out_valid_q && !m_axis_tready_i, !(advance && emits),
    "held result overwritten")
  `MTU_ASSERT_NEXT(a_result_follows, advance && emits, out_valid_q,
    "read or transform gave no result")
  `MTU_ASSERT_NEXT(a_silent_cmd, advance && !emits && !out_valid_q, !out_valid_q,
    "command without result produced one")
  `MTU_ASSERT_NEXT(a_identity, advance && (req_cmd_q == mtu_pkg::CMD_IDENTITY),
    (matrix_q[0] == mtu_pkg::FixOne) && (matrix_q[15] == mtu_pkg::FixOne)
      && (matrix_q[1] == '0) && (matrix_q[12] == '0),
    "identity command left wrong matrix")

endmodule

`default_nettype wire

[verif/tb_matrix_transform_unit.sv]
// ---------------------------------------------------------------------------
// Matrix transform unit testbench
// Streams identity, load, read, translate, scale, transform and spare-code
// requests into the block, keeps a shadow copy of the matrix to work out
// each read and transform result, and checks every returned result field
// by field under varying valid/ready idling and a long result-side hold-off.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_matrix_transform_unit;

  import mtu_pkg::*;

  // Codes 6 and 7 are not commands; the block must drop them.
  localparam logic [2:0] CmdSpare6 = 3'd6;
  localparam logic [2:0] CmdSpare7 = 3'd7;

  localparam data_t DataMax  = 32'sh7FFF_FFFF;
  localparam data_t DataMin  = 32'sh8000_0000;
  localparam data_t FixHalfN = 32'shFFFF_8000;  // -0.5
  localparam data_t FixTwoH  = 32'sh0002_8000;  // 2.5
  localparam data_t FixThree = 32'sh0003_0000;  // 3.0

  localparam int PhaseItems = 225;
  localparam int HoldCycles = 300;
  localparam int NumPhases  = 4;

  // One request as driven on the slave side.
  typedef struct packed {
    logic [2:0]      cmd;
    logic [IdxW-1:0] idx;
    data_t           value;
    data_t           x;
    data_t           y;
    data_t           z;
    data_t           w;
  } mtu_req_t;

  // One result as seen on the master side.
  typedef struct packed {
    data_t x;
    data_t y;
    data_t z;
    data_t w;
    logic  sat;
  } mtu_out_t;

  logic           clk_i  = 1'b0;
  logic           rst_ni = 1'b0;
  logic           s_axis_tvalid = 1'b0;
  logic           s_axis_tready;
  logic [167:0]   s_axis_tdata;
  logic [2:0]     s_axis_tuser;
  logic           m_axis_tvalid;
  logic           m_axis_tready = 1'b0;
  logic [127:0]   m_axis_tdata;
  logic [0:0]     m_axis_tuser;

  mtu_req_t       cur_req = '0;
  mtu_req_t       queued_requests[$];
  mtu_out_t       due_outputs[$];
  data_t          shadow_matrix[NumElem];

  int unsigned    send_idle_pct  = 0;
  int unsigned    recv_stall_pct = 0;
  logic           hold_go = 1'b0;
  logic           holding = 1'b0;
  int unsigned    mismatches = 0;

  // element_index [3:0], element_value [35:4], vec_x [67:36], vec_y [99:68],
  // vec_z [131:100], vec_w [163:132], zero fill [167:164]
  assign s_axis_tdata = {4'b0000, cur_req.w, cur_req.z, cur_req.y, cur_req.x,
                         cur_req.value, cur_req.idx};
  // command [2:0]
  assign s_axis_tuser = cur_req.cmd;

  matrix_transform_unit dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_axis_tvalid),
    .s_axis_tready_o (s_axis_tready),
    .s_axis_tdata_i  (s_axis_tdata),
    .s_axis_tuser_i  (s_axis_tuser),
    .m_axis_tvalid_o (m_axis_tvalid),
    .m_axis_tready_i (m_axis_tready),
    .m_axis_tdata_o  (m_axis_tdata),
    .m_axis_tuser_o  (m_axis_tuser)
  );

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  // ------------------------------------------------------------------------
  // Shadow matrix arithmetic
  // ------------------------------------------------------------------------

  // Full 64-bit product, floored by the arithmetic fraction shift.
  function automatic longint fix_product(input data_t a, input data_t b);
    longint p;
    p = longint'(a) * longint'(b);
    return p >>> FracBits;
  endfunction

  // Saturate an exact sum to 32 bits; hit is raised when it clamps.
  function automatic data_t clamp_word(input longint s, inout logic hit);
    if (s > longint'(DataMax)) begin
      hit = 1'b1;
      return DataMax;
    end
    if (s < longint'(DataMin)) begin
      hit = 1'b1;
      return DataMin;
    end
    return data_t'(s);
  endfunction

  // Apply one accepted request to the shadow matrix and queue the result
  // it should return, if any.
  task automatic run_command(input mtu_req_t rq);
    data_t    vin[4];
    longint   acc;
    logic     clamped;
    mtu_out_t res;
    vin     = '{rq.x, rq.y, rq.z, rq.w};
    clamped = 1'b0;
    res     = '0;
    case (rq.cmd)
      CMD_IDENTITY: begin
        for (int i = 0; i < NumElem; i++)
          shadow_matrix[i] = (i % 5 == 0) ? FixOne : '0;
      end
      CMD_LOAD: begin
        shadow_matrix[rq.idx] = rq.value;
      end
      CMD_READ: begin
        res.x = shadow_matrix[rq.idx];
        due_outputs.push_back(res);
      end
      CMD_TRANSLATE: begin
        // Only column 3 changes, and row r reads only its own entry there.
        for (int r = 0; r < NumDim; r++) begin
          acc = longint'(shadow_matrix[12 + r]);
          for (int c = 0; c < 3; c++)
            acc += fix_product(shadow_matrix[c * 4 + r], vin[c]);
          shadow_matrix[12 + r] = clamp_word(acc, clamped);
        end
      end
      CMD_SCALE: begin
        for (int c = 0; c < 3; c++)
          for (int r = 0; r < NumDim; r++)
            shadow_matrix[c * 4 + r] =
              clamp_word(fix_product(shadow_matrix[c * 4 + r], vin[c]), clamped);
      end
      CMD_TRANSFORM: begin
        for (int r = 0; r < NumDim; r++) begin
          acc = 0;
          for (int c = 0; c < NumDim; c++)
            acc += fix_product(shadow_matrix[c * 4 + r], vin[c]);
          case (r)
            0: res.x = clamp_word(acc, clamped);
            1: res.y = clamp_word(acc, clamped);
            2: res.z = clamp_word(acc, clamped);
            default: res.w = clamp_word(acc, clamped);
          endcase
        end
        res.sat = clamped;
        due_outputs.push_back(res);
      end
      default: ;  // spare codes: dropped
    endcase
  endtask

  // ------------------------------------------------------------------------
  // Checking
  // ------------------------------------------------------------------------

  task automatic log_mismatch(input string msg);
    $display("[%0t] MISMATCH: %s", $realtime, msg);
    mismatches++;
  endtask

  task automatic check_field(input string name, input logic [31:0] got,
                             input logic [31:0] want);
    if (got !== want)
      log_mismatch($sformatf("%s got %08h expected %08h", name, got, want));
  endtask

  // ------------------------------------------------------------------------
  // Stimulus helpers
  // ------------------------------------------------------------------------

  function automatic mtu_req_t make_req(input logic [2:0] cmd,
                                        input logic [IdxW-1:0] idx,
                                        input data_t value, input data_t x,
                                        input data_t y, input data_t z,
                                        input data_t w);
    mtu_req_t rq;
    rq = '{cmd: cmd, idx: idx, value: value, x: x, y: y, z: z, w: w};
    return rq;
  endfunction

  // Mostly modest values (within +/-8.0) so that chains of scale and
  // translate do not pin every element at a rail; extremes and full-range
  // words still turn up regularly.
  function automatic data_t fix_value();
    case ($urandom_range(9))
      0:       return DataMax;
      1:       return DataMin;
      2, 3:    return data_t'($urandom);
      4:       return '0;
      default: return data_t'(int'($urandom_range(1 << 20)) - (1 << 19));
    endcase
  endfunction

  function automatic mtu_req_t random_request();
    mtu_req_t    rq;
    int unsigned roll;
    rq = make_req(CMD_IDENTITY, IdxW'($urandom_range(NumElem - 1)), fix_value(),
                  fix_value(), fix_value(), fix_value(), fix_value());
    roll = $urandom_range(99);
    if (roll < 10)      rq.cmd = CMD_IDENTITY;
    else if (roll < 30) rq.cmd = CMD_LOAD;
    else if (roll < 45) rq.cmd = CMD_READ;
    else if (roll < 55) rq.cmd = CMD_TRANSLATE;
    else if (roll < 65) rq.cmd = CMD_SCALE;
    else if (roll < 95) rq.cmd = CMD_TRANSFORM;
    else                rq.cmd = $urandom_range(1) ? CmdSpare7 : CmdSpare6;
    return rq;
  endfunction

  // Sender pause: hold off until every request has gone in and every
  // expected result has come back.
  task automatic wait_for_drain();
    while (queued_requests.size() != 0 || s_axis_tvalid || due_outputs.size() != 0)
      @(negedge clk_i);
  endtask

  // ------------------------------------------------------------------------
  // Request driver: offers the next queued request, idling at random, and
  // hands each accepted request to the shadow matrix.
  // ------------------------------------------------------------------------
  always @(posedge clk_i) begin : request_driver
    logic offer;
    if (rst_ni) begin
      if (s_axis_tvalid && s_axis_tready)
        run_command(cur_req);
      if (!s_axis_tvalid || s_axis_tready) begin
        offer = (queued_requests.size() != 0) &&
                ($urandom_range(99) >= send_idle_pct);
        if (offer)
          cur_req <= queued_requests.pop_front();
        s_axis_tvalid <= offer;
      end
    end
  end

  // Result-side ready: random stalls, forced low during the hold-off.
  always @(posedge clk_i) begin : result_receiver
    if (rst_ni)
      m_axis_tready <= !holding && ($urandom_range(99) >= recv_stall_pct);
  end

  // Long hold-off, counted here, so the result register fills and the
  // request side backs up while the driver keeps offering.
  initial begin : result_hold_off
    wait (hold_go);
    @(posedge clk_i);
    holding <= 1'b1;
    repeat (HoldCycles) @(posedge clk_i);
    holding <= 1'b0;
  end

  // ------------------------------------------------------------------------
  // Result monitor: compares each accepted result with the oldest one due.
  // ------------------------------------------------------------------------
  always @(posedge clk_i) begin : result_monitor
    mtu_out_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (due_outputs.size() == 0) begin
        log_mismatch($sformatf("result %032h with none outstanding", m_axis_tdata));
      end else begin
        want = due_outputs.pop_front();
        check_field("out_x", m_axis_tdata[31:0],   want.x);
        check_field("out_y", m_axis_tdata[63:32],  want.y);
        check_field("out_z", m_axis_tdata[95:64],  want.z);
        check_field("out_w", m_axis_tdata[127:96], want.w);
        check_field("saturated", 32'(m_axis_tuser[0]), 32'(want.sat));
      end
    end
  end

  // ------------------------------------------------------------------------
  // Sequence: reset, directed requests, then four idling phases.
  // ------------------------------------------------------------------------
  initial begin : stimulus
    int unsigned send_pct[NumPhases];
    int unsigned recv_pct[NumPhases];
    send_pct = '{0, 84, 0, 28};
    recv_pct = '{0, 0, 84, 28};

    for (int i = 0; i < NumElem; i++)
      shadow_matrix[i] = (i % 5 == 0) ? FixOne : '0;

    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Directed: identity after reset, rails on load and vector, clamping in
    // transform, and the two spare codes.
    queued_requests.push_back(make_req(CMD_READ, 4'd0, '0, '0, '0, '0, '0));
    queued_requests.push_back(make_req(CMD_READ, 4'd1, '0, '0, '0, '0, '0));
    queued_requests.push_back(make_req(CMD_READ, 4'd15, '0, '0, '0, '0, '0));
    queued_requests.push_back(make_req(CMD_TRANSFORM, 4'd0, '0,
                                       DataMax, DataMin, '0, -32'sd1));
    queued_requests.push_back(make_req(CMD_LOAD, 4'd0, DataMax, '0, '0, '0, '0));
    queued_requests.push_back(make_req(CMD_LOAD, 4'd5, DataMin, '0, '0, '0, '0));
    queued_requests.push_back(make_req(CMD_LOAD, 4'd15, -32'sd1, '0, '0, '0, '0));
    queued_requests.push_back(make_req(CMD_TRANSFORM, 4'd0, '0,
                                       DataMin, DataMin, DataMin, DataMin));
    queued_requests.push_back(make_req(CMD_READ, 4'd0, '0, '0, '0, '0, '0));
    queued_requests.push_back(make_req(CMD_READ, 4'd5, '0, '0, '0, '0, '0));
    queued_requests.push_back(make_req(CMD_READ, 4'd15, '0, '0, '0, '0, '0));
    queued_requests.push_back(make_req(CMD_IDENTITY, 4'd15, DataMin,
                                       DataMax, DataMax, DataMax, DataMax));
    queued_requests.push_back(make_req(CMD_TRANSLATE, 4'd0, '0,
                                       DataMax, DataMin, FixThree, DataMax));
    for (int i = 12; i < NumElem; i++)
      queued_requests.push_back(make_req(CMD_READ, IdxW'(i), '0, '0, '0, '0, '0));
    queued_requests.push_back(make_req(CMD_SCALE, 4'd0, '0,
                                       DataMin, DataMax, FixHalfN, DataMin));
    queued_requests.push_back(make_req(CMD_TRANSFORM, 4'd0, '0,
                                       FixOne, FixOne, FixOne, FixOne));
    queued_requests.push_back(make_req(CmdSpare6, 4'd0, DataMax,
                                       DataMax, DataMax, DataMax, DataMax));
    queued_requests.push_back(make_req(CmdSpare7, 4'd15, DataMin,
                                       DataMin, DataMin, DataMin, DataMin));
    queued_requests.push_back(make_req(CMD_READ, 4'd0, '0, '0, '0, '0, '0));
    queued_requests.push_back(make_req(CMD_IDENTITY, 4'd0, '0, '0, '0, '0, '0));
    queued_requests.push_back(make_req(CMD_TRANSFORM, 4'd0, '0,
                                       FixTwoH, FixHalfN, FixThree, FixOne));
    wait_for_drain();

    // Random phases; the first one also carries the long result hold-off.
    for (int ph = 0; ph < NumPhases; ph++) begin
      send_idle_pct  = send_pct[ph];
      recv_stall_pct = recv_pct[ph];
      if (ph == 0)
        hold_go = 1'b1;
      for (int n = 0; n < PhaseItems; n++)
        queued_requests.push_back(random_request());
      wait_for_drain();
    end

    // Let any stray result surface before the verdict.
    repeat (8) @(posedge clk_i);
    if (mismatches == 0 && due_outputs.size() == 0)
      $display("Test completed successfully");
    else
      $display("Test completed with failures");
    $finish;
  end

  // Watchdog, far beyond the slowest legal run.
  initial begin : watchdog
    #400_000;
    $display("Test completed with failures");
    $finish;
  end

endmodule

[matrix_transform_unit.f]
+incdir+rtl/core
rtl/core/mtu_pkg.sv
rtl/core/mtu_lane.sv
rtl/core/matrix_transform_unit.sv
verif/tb_matrix_transform_unit.sv
